// ===== rtl/core/jsu_pkg.sv =====
`timescale 1ns / 1ps

package jsu_pkg;

    // Character codes
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;

    // Surrogate ranges
    localparam logic [15:0] SURR_HI_MIN = 16'hD800;
    localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
    localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
    localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;

    // UTF-8 length limits and lead/continuation marks
    localparam logic [20:0] CP_LIM_1 = 21'h80;
    localparam logic [20:0] CP_LIM_2 = 21'h800;
    localparam logic [20:0] CP_LIM_3 = 21'h10000;
    localparam logic [7:0]  LEAD_2   = 8'hC0;
    localparam logic [7:0]  LEAD_3   = 8'hE0;
    localparam logic [7:0]  LEAD_4   = 8'hF0;
    localparam logic [7:0]  CONT     = 8'h80;

    // Most bytes one request can produce
    localparam int unsigned MAX_RUN = 8;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       body_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_end;
    } out_item_t;

    // Up to four bytes, first byte in the low lane
    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  len;
    } seg_t;

    // Result run, first byte in the low lane
    typedef struct packed {
        logic [8*MAX_RUN-1:0]     data;
        logic [$clog2(MAX_RUN):0] len;
    } run_t;

    function automatic seg_t utf8_encode(input logic [20:0] cp);
        seg_t r;
        r.bytes = '0;
        if (cp < CP_LIM_1) begin
            r.bytes[7:0] = cp[7:0];
            r.len = 3'd1;
        end else if (cp < CP_LIM_2) begin
            r.bytes[7:0]  = LEAD_2 | {3'b000, cp[10:6]};
            r.bytes[15:8] = CONT | {2'b00, cp[5:0]};
            r.len = 3'd2;
        end else if (cp < CP_LIM_3) begin
            r.bytes[7:0]   = LEAD_3 | {4'b0000, cp[15:12]};
            r.bytes[15:8]  = CONT | {2'b00, cp[11:6]};
            r.bytes[23:16] = CONT | {2'b00, cp[5:0]};
            r.len = 3'd3;
        end else begin
            r.bytes[7:0]   = LEAD_4 | {5'b00000, cp[20:18]};
            r.bytes[15:8]  = CONT | {2'b00, cp[17:12]};
            r.bytes[23:16] = CONT | {2'b00, cp[11:6]};
            r.bytes[31:24] = CONT | {2'b00, cp[5:0]};
            r.len = 3'd4;
        end
        return r;
    endfunction

    // Bit 4 set when the byte is a hex digit, low nibble is its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic [7:0] esc_map(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            CH_N:    r = 8'h0A;
            CH_R:    r = 8'h0D;
            CH_T:    r = 8'h09;
            CH_B:    r = 8'h08;
            CH_F:    r = 8'h0C;
            default: r = c;
        endcase
        return r;
    endfunction

    // Append the first seg.len bytes of seg to the run
    function automatic run_t run_append(input run_t run, input seg_t seg);
        run_t                 r;
        logic [8*MAX_RUN-1:0] masked;
        masked = '0;
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < seg.len) begin
                masked[8*i +: 8] = seg.bytes[8*i +: 8];
            end
        end
        r.data = run.data | (masked << {run.len, 3'b000});
        r.len  = run.len + ($clog2(MAX_RUN) + 1)'(seg.len);
        return r;
    endfunction

endpackage

// ===== rtl/core/json_string_unescape_utf8_unit.sv =====
`timescale 1ns / 1ps

// Channel   Ports                     Handshake      Payload
// input     s_valid s_ready s_data    valid/ready    in_item_t  (in_byte, body_end)
// result    m_valid m_ready m_data    valid/ready    out_item_t (out_byte, run_last, string_end)
//
// An accepted byte is decoded in the cycle it is accepted; its result run (0 to 8
// bytes) lands in one result shift register that presents one byte per cycle.
// A new byte is taken while the last byte of the previous run leaves, so runs of
// at most one byte flow at one byte per cycle; a longer run holds s_ready low
// until its last byte leaves. aresetn is synchronous, active low: decoder back
// to plain text, result run empty. Stalls on m_ready hold the current byte and s_ready.

module json_string_unescape_utf8_unit
    import jsu_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_ESC,
        MODE_HEX1,
        MODE_PAIR_BS,
        MODE_PAIR_U,
        MODE_HEX2
    } mode_t;

    localparam int CNT_W = $clog2(MAX_RUN) + 1;

    mode_t       mode_reg, mode_next;
    logic [1:0]  count_reg, count_next;
    logic [11:0] hex_reg, hex_next;
    logic [9:0]  pend_reg, pend_next;
    logic [7:0]  held_reg [3];
    logic        held_we;

    logic [8*MAX_RUN-1:0] run_data_reg;
    logic [CNT_W-1:0]     run_cnt_reg;
    logic                 run_end_reg;

    logic        accept;
    logic        take;
    logic [7:0]  c;
    logic        eob;
    logic        plain_esc;
    logic [4:0]  dig;
    logic [15:0] full;
    logic [20:0] pair_cp;
    logic [7:0]  held_view [3];
    logic        a_en;
    logic        b_en;
    logic [1:0]  b_cnt;
    seg_t        a_seg, b_seg, c_seg;
    run_t        run_new;

    assign c         = s_data.in_byte;
    assign eob       = s_data.body_end;
    assign plain_esc = (c == CH_BACKSLASH) && !eob;
    assign dig       = hex_digit(c);
    assign full      = {hex_reg, dig[3:0]};
    assign pair_cp   = SUPP_BASE + 21'({pend_reg, full[9:0]});

    assign take    = m_valid && m_ready;
    assign s_ready = (run_cnt_reg == '0) || ((run_cnt_reg == CNT_W'(1)) && m_ready);
    assign accept  = s_valid && s_ready;

    // Decode one byte: next state and the three output segments
    always_comb begin
        mode_next  = mode_reg;
        count_next = count_reg;
        hex_next   = hex_reg;
        pend_next  = pend_reg;
        held_we    = 1'b0;
        a_en       = 1'b0;
        b_en       = 1'b0;
        b_cnt      = 2'd0;
        c_seg      = '0;
        unique case (mode_reg) inside
            MODE_ESC: begin
                if (c == CH_U && !eob) begin
                    mode_next  = MODE_HEX1;
                    count_next = 2'd0;
                    hex_next   = '0;
                end else begin
                    c_seg.bytes[7:0] = esc_map(c);
                    c_seg.len        = 3'd1;
                    mode_next        = MODE_NORMAL;
                end
            end
            MODE_HEX1, MODE_HEX2: begin
                if (dig[4]) begin
                    if (count_reg == 2'd3) begin
                        if (mode_reg == MODE_HEX2 && full >= SURR_LO_MIN
                                && full <= SURR_LO_MAX) begin
                            c_seg     = utf8_encode(pair_cp);
                            mode_next = MODE_NORMAL;
                        end else begin
                            a_en = (mode_reg == MODE_HEX2);
                            if (full >= SURR_HI_MIN && full <= SURR_HI_MAX && !eob) begin
                                pend_next = full[9:0];
                                mode_next = MODE_PAIR_BS;
                            end else begin
                                c_seg     = utf8_encode({5'b00000, full});
                                mode_next = MODE_NORMAL;
                            end
                        end
                    end else begin
                        held_we    = 1'b1;
                        count_next = count_reg + 2'd1;
                        hex_next   = full[11:0];
                        if (eob) begin
                            a_en      = (mode_reg == MODE_HEX2);
                            b_en      = 1'b1;
                            b_cnt     = count_reg + 2'd1;
                            mode_next = MODE_NORMAL;
                        end
                    end
                end else begin
                    // Bad digit: replay what was gathered, then treat byte as plain
                    a_en  = (mode_reg == MODE_HEX2);
                    b_en  = 1'b1;
                    b_cnt = count_reg;
                    if (plain_esc) begin
                        mode_next = MODE_ESC;
                    end else begin
                        c_seg.bytes[7:0] = c;
                        c_seg.len        = 3'd1;
                        mode_next        = MODE_NORMAL;
                    end
                end
            end
            MODE_PAIR_BS: begin
                if (plain_esc) begin
                    mode_next = MODE_PAIR_U;
                end else begin
                    a_en             = 1'b1;
                    c_seg.bytes[7:0] = c;
                    c_seg.len        = 3'd1;
                    mode_next        = MODE_NORMAL;
                end
            end
            MODE_PAIR_U: begin
                if (c == CH_U && !eob) begin
                    mode_next  = MODE_HEX2;
                    count_next = 2'd0;
                    hex_next   = '0;
                end else begin
                    a_en             = 1'b1;
                    c_seg.bytes[7:0] = esc_map(c);
                    c_seg.len        = 3'd1;
                    mode_next        = MODE_NORMAL;
                end
            end
            default: begin
                if (plain_esc) begin
                    mode_next = MODE_ESC;
                end else begin
                    c_seg.bytes[7:0] = c;
                    c_seg.len        = 3'd1;
                    mode_next        = MODE_NORMAL;
                end
            end
        endcase

        // End of body returns the decoder to its reset state
        if (eob) begin
            mode_next  = MODE_NORMAL;
            count_next = 2'd0;
            hex_next   = '0;
            pend_next  = '0;
        end
    end

    // Held digits as seen by a replay, including a digit arriving now
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            held_view[i] = (held_we && count_reg == 2'(i)) ? c : held_reg[i];
        end
    end

    // Pending high surrogate, replayed digits, then the current segment
    always_comb begin
        a_seg       = utf8_encode({5'b00000, SURR_HI_MIN[15:10], pend_reg});
        a_seg.len   = a_en ? 3'd3 : 3'd0;
        b_seg.bytes = {held_view[2], held_view[1], held_view[0], CH_U};
        b_seg.len   = b_en ? (3'd1 + 3'(b_cnt)) : 3'd0;
        run_new     = '0;
        run_new     = run_append(run_new, a_seg);
        run_new     = run_append(run_new, b_seg);
        run_new     = run_append(run_new, c_seg);
    end

    // Hold decoder state and the result run
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_NORMAL;
            count_reg   <= 2'd0;
            hex_reg     <= '0;
            pend_reg    <= '0;
            run_cnt_reg <= '0;
            run_end_reg <= 1'b0;
        end else begin
            if (accept) begin
                mode_reg    <= mode_next;
                count_reg   <= count_next;
                hex_reg     <= hex_next;
                pend_reg    <= pend_next;
                run_cnt_reg <= run_new.len;
                run_end_reg <= eob;
            end else if (take) begin
                run_cnt_reg <= run_cnt_reg - CNT_W'(1);
            end
        end
    end

    // Load or advance the result bytes; store raw digits for replay
    always_ff @(posedge aclk) begin
        if (accept) begin
            run_data_reg <= run_new.data;
        end else if (take) begin
            run_data_reg <= run_data_reg >> 8;
        end
        if (accept && held_we) begin
            held_reg[count_reg] <= c;
        end
    end

    assign m_valid           = (run_cnt_reg != '0);
    assign m_data.out_byte   = run_data_reg[7:0];
    assign m_data.run_last   = (run_cnt_reg == CNT_W'(1));
    assign m_data.string_end = (run_cnt_reg == CNT_W'(1)) && run_end_reg;

    // A run never exceeds its buffer
    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        run_cnt_reg <= CNT_W'(MAX_RUN))
        else $error("result run longer than buffer");

    // Last byte of a body always yields at least one result
    a_end_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && eob) |=> (run_cnt_reg != '0) && run_end_reg)
        else $error("body end produced no result");

    // Body end returns the decoder to plain text
    a_end_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && eob) |=> (mode_reg == MODE_NORMAL) && (pend_reg == '0))
        else $error("decoder not idle after body end");

endmodule

// ===== sim/tb_json_string_unescape_utf8_unit.sv =====
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8_unit;
    import jsu_pkg::*;

    // Characters not in the package
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;

    localparam int N_DIRECTED     = 25;
    localparam int N_RANDOM       = 345;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int IDLE_PCT       = 37;

    typedef enum logic [2:0] {
        DM_NORMAL,
        DM_ESC,
        DM_HEX1,
        DM_PAIR_BS,
        DM_PAIR_U,
        DM_HEX2
    } dec_mode_t;

    // Directed row: byte, end flag, hand-typed result bytes (low lane first)
    typedef struct packed {
        logic [7:0]  in_byte;
        logic        body_end;
        logic        typed;
        logic [2:0]  n_bytes;
        logic [31:0] bytes;
    } dir_row_t;

    typedef struct {
        in_item_t    item;
        bit          typed;
        int          n_bytes;
        logic [31:0] bytes;
    } stim_row_t;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    // Decoder state of the predictor
    dec_mode_t   mode_q;
    logic [2:0]  ndig_q;
    logic [15:0] hexacc_q;
    logic [7:0]  digits_q [3];
    logic [15:0] high_q;

    out_item_t   run_buf [$];
    out_item_t   utf8_due_q [$];
    stim_row_t   stim_rows [$];
    logic [7:0]  str_q [$];
    dir_row_t    directed_tab [N_DIRECTED];

    int n_accepted   = 0;
    int errors       = 0;
    int stall_cycles = 0;

    json_string_unescape_utf8_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int hex_val(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_A_LO && c <= CH_F_LO) return int'(c - CH_A_LO) + 10;
        if (c >= CH_A_UP && c <= CH_F_UP) return int'(c - CH_A_UP) + 10;
        return -1;
    endfunction

    function automatic logic [7:0] ctrl_of(input logic [7:0] c);
        case (c)
            CH_N:    return 8'h0A;
            CH_R:    return 8'h0D;
            CH_T:    return 8'h09;
            CH_B:    return 8'h08;
            CH_F:    return 8'h0C;
            default: return c;
        endcase
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        out_item_t o;
        o.out_byte   = b;
        o.run_last   = 1'b0;
        o.string_end = 1'b0;
        if (run_buf.size() < MAX_RUN) run_buf.push_back(o);
    endfunction

    function automatic void put_utf8(input logic [20:0] cp);
        if (cp < CP_LIM_1) begin
            push_byte(cp[7:0]);
        end else if (cp < CP_LIM_2) begin
            push_byte(LEAD_2 | {3'b000, cp[10:6]});
            push_byte(CONT | {2'b00, cp[5:0]});
        end else if (cp < CP_LIM_3) begin
            push_byte(LEAD_3 | {4'b0000, cp[15:12]});
            push_byte(CONT | {2'b00, cp[11:6]});
            push_byte(CONT | {2'b00, cp[5:0]});
        end else begin
            push_byte(LEAD_4 | {5'b00000, cp[20:18]});
            push_byte(CONT | {2'b00, cp[17:12]});
            push_byte(CONT | {2'b00, cp[11:6]});
            push_byte(CONT | {2'b00, cp[5:0]});
        end
    endfunction

    function automatic logic [20:0] pair_cp(input logic [15:0] hi, input logic [15:0] lo);
        return SUPP_BASE + (21'(hi - SURR_HI_MIN) << 10) + 21'(lo - SURR_LO_MIN);
    endfunction

    function automatic void clear_decoder();
        mode_q      = DM_NORMAL;
        ndig_q      = '0;
        hexacc_q    = '0;
        digits_q[0] = '0;
        digits_q[1] = '0;
        digits_q[2] = '0;
        high_q      = '0;
    endfunction

    function automatic void plain_byte(input logic [7:0] c, input logic fin);
        mode_q = DM_NORMAL;
        if (c == CH_BACKSLASH && !fin) mode_q = DM_ESC;
        else push_byte(c);
    endfunction

    function automatic void close_cp(input logic [15:0] cp, input logic fin);
        if (cp >= SURR_HI_MIN && cp <= SURR_HI_MAX && !fin) begin
            high_q = cp;
            mode_q = DM_PAIR_BS;
        end else begin
            put_utf8(21'(cp));
            mode_q = DM_NORMAL;
        end
    endfunction

    function automatic void replay_digits();
        push_byte(CH_U);
        for (int i = 0; i < int'(ndig_q) && i < 3; i++) push_byte(digits_q[i]);
    endfunction

    // Decode one accepted byte into run_buf
    function automatic void decode_item(input in_item_t it);
        logic [7:0] c;
        logic       fin;
        int         d;
        out_item_t  last;
        c   = it.in_byte;
        fin = it.body_end;
        run_buf.delete();
        case (mode_q) inside
            DM_ESC: begin
                if (c == CH_U && !fin) begin
                    mode_q   = DM_HEX1;
                    ndig_q   = '0;
                    hexacc_q = '0;
                end else begin
                    push_byte(ctrl_of(c));
                    mode_q = DM_NORMAL;
                end
            end
            DM_HEX1, DM_HEX2: begin
                d = hex_val(c);
                if (d >= 0) begin
                    hexacc_q = {hexacc_q[11:0], 4'(d)};
                    if (ndig_q >= 3'd3) begin
                        if (mode_q == DM_HEX2 && hexacc_q >= SURR_LO_MIN
                            && hexacc_q <= SURR_LO_MAX) begin
                            put_utf8(pair_cp(high_q, hexacc_q));
                            mode_q = DM_NORMAL;
                        end else begin
                            if (mode_q == DM_HEX2) put_utf8(21'(high_q));
                            close_cp(hexacc_q, fin);
                        end
                    end else begin
                        digits_q[ndig_q] = c;
                        ndig_q++;
                        if (fin) begin
                            if (mode_q == DM_HEX2) put_utf8(21'(high_q));
                            replay_digits();
                            mode_q = DM_NORMAL;
                        end
                    end
                end else begin
                    if (mode_q == DM_HEX2) put_utf8(21'(high_q));
                    replay_digits();
                    plain_byte(c, fin);
                end
            end
            DM_PAIR_BS: begin
                if (c == CH_BACKSLASH && !fin) begin
                    mode_q = DM_PAIR_U;
                end else begin
                    put_utf8(21'(high_q));
                    plain_byte(c, fin);
                end
            end
            DM_PAIR_U: begin
                if (c == CH_U && !fin) begin
                    mode_q   = DM_HEX2;
                    ndig_q   = '0;
                    hexacc_q = '0;
                end else begin
                    put_utf8(21'(high_q));
                    push_byte(ctrl_of(c));
                    mode_q = DM_NORMAL;
                end
            end
            default: plain_byte(c, fin);
        endcase
        if (fin) clear_decoder();
        if (run_buf.size() > 0) begin
            last = run_buf[run_buf.size() - 1];
            last.run_last = 1'b1;
            if (fin) last.string_end = 1'b1;
            run_buf[run_buf.size() - 1] = last;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic void add_row(input logic [7:0] b, input logic fin);
        stim_row_t r;
        r.item.in_byte  = b;
        r.item.body_end = fin;
        r.typed         = 1'b0;
        r.n_bytes       = 0;
        r.bytes         = '0;
        stim_rows.push_back(r);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return CH_ZERO + 8'(nib);
        return ($urandom_range(1) ? CH_A_LO : CH_A_UP) + 8'(nib) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (hex_val(b) >= 0) b = 8'($urandom_range(255));
        return b;
    endfunction

    function automatic logic [7:0] plain_pick();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == CH_BACKSLASH) b = CH_A_UP;
        return b;
    endfunction

    function automatic logic [15:0] rand_cp();
        case ($urandom_range(6))
            0:       return 16'($urandom_range(16'h007F));
            1:       return 16'($urandom_range(16'h07FF, 16'h0080));
            2:       return 16'($urandom_range(16'hFFFF, 16'h0800));
            3:       return 16'($urandom_range(SURR_LO_MAX, SURR_LO_MIN));
            4:       return 16'($urandom_range(SURR_HI_MAX, SURR_HI_MIN));
            5:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic void add_escape_u(input logic [15:0] v);
        str_q.push_back(CH_BACKSLASH);
        str_q.push_back(CH_U);
        for (int i = 3; i >= 0; i--) str_q.push_back(hex_char(v[4*i +: 4]));
    endfunction

    // Broken \u: some digits, then a byte that is not hex
    function automatic void add_bad_u();
        int n;
        n = $urandom_range(3);
        str_q.push_back(CH_BACKSLASH);
        str_q.push_back(CH_U);
        repeat (n) str_q.push_back(hex_char(4'($urandom_range(15))));
        str_q.push_back(non_hex());
    endfunction

    function automatic void add_token();
        logic [15:0] v;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 30) begin
            str_q.push_back(plain_pick());
        end else if (pick < 45) begin
            str_q.push_back(CH_BACKSLASH);
            case ($urandom_range(8))
                0:       str_q.push_back(CH_N);
                1:       str_q.push_back(CH_R);
                2:       str_q.push_back(CH_T);
                3:       str_q.push_back(CH_B);
                4:       str_q.push_back(CH_F);
                5:       str_q.push_back(CH_QUOTE);
                6:       str_q.push_back(CH_SLASH);
                7:       str_q.push_back(CH_BACKSLASH);
                default: str_q.push_back(8'($urandom_range(255)));
            endcase
        end else if (pick < 65) begin
            add_escape_u(rand_cp());
        end else if (pick < 85) begin
            add_escape_u(16'($urandom_range(SURR_HI_MAX, SURR_HI_MIN)));
            add_escape_u(16'($urandom_range(SURR_LO_MAX, SURR_LO_MIN)));
        end else if (pick < 93) begin
            // High half followed by something that is not an escaped low half
            add_escape_u(16'($urandom_range(SURR_HI_MAX, SURR_HI_MIN)));
            case ($urandom_range(3))
                0: str_q.push_back(plain_pick());
                1: begin
                    str_q.push_back(CH_BACKSLASH);
                    v = 16'($urandom_range(255));
                    if (v[7:0] == CH_U) v[7:0] = CH_N;
                    str_q.push_back(v[7:0]);
                end
                2: begin
                    v = rand_cp();
                    if (v >= SURR_LO_MIN && v <= SURR_LO_MAX) v = SURR_HI_MIN;
                    add_escape_u(v);
                end
                default: add_bad_u();
            endcase
        end else begin
            add_bad_u();
        end
    endfunction

    function automatic void build_stimulus();
        stim_row_t r;
        int        cut;
        directed_tab = '{
            '{CH_A_UP,      1'b1, 1'b1, 3'd1, 32'h0000_0041},
            '{8'hFF,        1'b1, 1'b1, 3'd1, 32'h0000_00FF},
            '{8'h00,        1'b0, 1'b1, 3'd1, 32'h0000_0000},
            // trailing backslash comes out as itself
            '{CH_BACKSLASH, 1'b1, 1'b1, 3'd1, 32'h0000_005C},
            // \u0000 at the end of the body
            '{CH_BACKSLASH, 1'b0, 1'b0, 3'd0, 32'h0},
            '{CH_U,         1'b0, 1'b0, 3'd0, 32'h0},
            '{CH_ZERO,      1'b0, 1'b0, 3'd0, 32'h0},
            '{CH_ZERO,      1'b0, 1'b0, 3'd0, 32'h0},
            '{CH_ZERO,      1'b0, 1'b0, 3'd0, 32'h0},
            '{CH_ZERO,      1'b1, 1'b1, 3'd1, 32'h0000_0000},
            // high half, then \n breaks the pair
            '{CH_BACKSLASH, 1'b0, 1'b0, 3'd0, 32'h0},
            '{CH_U,         1'b0, 1'b0, 3'd0, 32'h0},
            '{8'h44,        1'b0, 1'b0, 3'd0, 32'h0},
            '{8'h38,        1'b0, 1'b0, 3'd0, 32'h0},
            '{8'h33,        1'b0, 1'b0, 3'd0, 32'h0},
            '{8'h44,        1'b0, 1'b0, 3'd0, 32'h0},
            '{CH_BACKSLASH, 1'b0, 1'b0, 3'd0, 32'h0},
            '{CH_N,         1'b0, 1'b0, 3'd0, 32'h0},
            // non-hex byte inside \u
            '{CH_BACKSLASH, 1'b0, 1'b0, 3'd0, 32'h0},
            '{CH_U,         1'b0, 1'b0, 3'd0, 32'h0},
            '{8'h31,        1'b0, 1'b0, 3'd0, 32'h0},
            '{8'h78,        1'b1, 1'b0, 3'd0, 32'h0},
            // body ends after one digit
            '{CH_BACKSLASH, 1'b0, 1'b0, 3'd0, 32'h0},
            '{CH_U,         1'b0, 1'b0, 3'd0, 32'h0},
            '{CH_A_LO,      1'b1, 1'b0, 3'd0, 32'h0}
        };
        foreach (directed_tab[k]) begin
            r.item.in_byte  = directed_tab[k].in_byte;
            r.item.body_end = directed_tab[k].body_end;
            r.typed         = directed_tab[k].typed;
            r.n_bytes       = int'(directed_tab[k].n_bytes);
            r.bytes         = directed_tab[k].bytes;
            stim_rows.push_back(r);
        end

        while (stim_rows.size() < N_DIRECTED + N_RANDOM) begin
            str_q.delete();
            if ($urandom_range(99) < 6) begin
                // Noise: any byte, end flag anywhere
                repeat ($urandom_range(6, 1))
                    add_row(8'($urandom_range(255)), 1'($urandom_range(1)));
            end else begin
                repeat ($urandom_range(6, 1)) add_token();
                // Cut some strings short, often in the middle of an escape
                if ($urandom_range(99) < 12) begin
                    cut = $urandom_range(str_q.size(), 1);
                    while (str_q.size() > cut) void'(str_q.pop_back());
                end
                foreach (str_q[k]) add_row(str_q[k], k == str_q.size() - 1);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Drive
    // ------------------------------------------------------------------

    task automatic offer_item(input in_item_t it, input bit no_gaps);
        if (!no_gaps) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    initial begin : main
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        clear_decoder();
        build_stimulus();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (stim_rows[k]) offer_item(stim_rows[k].item, k >= 150 && k < 250);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (n_accepted < stim_rows.size() || utf8_due_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Result side: random stalls, one long hold-off, one stretch always ready
    initial begin : sink
        int unsigned cyc;
        cyc = 0;
        m_ready <= 1'b0;
        repeat (6) @(posedge aclk);
        forever begin
            if (cyc >= 300 && cyc < 400) begin
                m_ready <= 1'b0;
            end else if (cyc >= 600 && cyc < 800) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
            @(posedge aclk);
            cyc++;
        end
    end

    // ------------------------------------------------------------------
    // Check
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : monitor
        stim_row_t row;
        out_item_t o;
        out_item_t want;
        if (aresetn) begin
            // Predict first so a same-cycle result still finds its entry
            if (s_valid && s_ready && n_accepted < stim_rows.size()) begin
                decode_item(s_data);
                row = stim_rows[n_accepted];
                if (row.typed) begin
                    for (int k = 0; k < row.n_bytes; k++) begin
                        o.out_byte   = row.bytes[8*k +: 8];
                        o.run_last   = (k == row.n_bytes - 1);
                        o.string_end = o.run_last & row.item.body_end;
                        utf8_due_q.push_back(o);
                    end
                end else begin
                    foreach (run_buf[k]) utf8_due_q.push_back(run_buf[k]);
                end
                n_accepted++;
            end
            if (m_valid && m_ready) begin
                if (utf8_due_q.size() == 0) begin
                    $error("unexpected result byte %02h", m_data.out_byte);
                    errors++;
                end else begin
                    want = utf8_due_q.pop_front();
                    if (m_data.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %02h, got %02h",
                               want.out_byte, m_data.out_byte);
                        errors++;
                    end
                    if (m_data.run_last !== want.run_last) begin
                        $error("run_last: expected %0b, got %0b",
                               want.run_last, m_data.run_last);
                        errors++;
                    end
                    if (m_data.string_end !== want.string_end) begin
                        $error("string_end: expected %0b, got %0b",
                               want.string_end, m_data.string_end);
                        errors++;
                    end
                end
            end
        end
    end

    // Abort when no handshake happens for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
